[rtl/core/multi_window_running_stats_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef MULTI_WINDOW_RUNNING_STATS_TOP_MACROS_SVH
`define MULTI_WINDOW_RUNNING_STATS_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MWRS_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MWRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mwrs_pkg.sv]
`default_nettype none

package mwrs_pkg;

  localparam int unsigned WINDOW_BASE   = 4;
  localparam int unsigned WINDOW_LEVELS = 3;
  localparam int unsigned HISTORY_DEPTH = 64;
  localparam int unsigned SAMPLE_BITS   = 32;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned LEVEL_W = 3;

  localparam int unsigned LVL_W  = (WINDOW_LEVELS > 1) ? $clog2(WINDOW_LEVELS) : 1;
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  typedef logic [CNT_W-1:0] len_t;
  typedef len_t len_tab_t [WINDOW_LEVELS];

  function automatic len_tab_t win_len_table();
    len_tab_t    tab;
    int unsigned len;
    len = 1;
    for (int k = 0; k < WINDOW_LEVELS; k++) begin
      len = len * WINDOW_BASE;
      if (len >= HISTORY_DEPTH) begin
        len = HISTORY_DEPTH;
      end
      tab[k] = CNT_W'(len);
    end
    return tab;
  endfunction

  localparam len_tab_t WIN_LEN = win_len_table();

  // Address of the stored sample the given number of entries behind the newest one.
  function automatic logic [ADDR_W-1:0] hist_addr(logic [ADDR_W-1:0] top,
                                                  logic [CNT_W-1:0]  back);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(top) + (CNT_W+1)'(HISTORY_DEPTH) - (CNT_W+1)'(back);
    if (t >= (CNT_W+1)'(HISTORY_DEPTH)) begin
      t = t - (CNT_W+1)'(HISTORY_DEPTH);
    end
    return t[ADDR_W-1:0];
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_LEAVE,
    ST_SCAN,
    ST_DIV,
    ST_DWAIT,
    ST_EMIT,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/mwrs_in_if.sv]
`default_nettype none

interface mwrs_in_if;
  import mwrs_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;
  logic              restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

[rtl/core/mwrs_out_if.sv]
`default_nettype none

interface mwrs_out_if;
  import mwrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] window_level;
  logic [DATA_W-1:0]  window_mean;
  logic [DATA_W-1:0]  window_max;
  logic [DATA_W-1:0]  window_min;
  logic [DATA_W-1:0]  latest_sample;
  logic               last_level;

  modport source (output valid, output window_level, output window_mean,
                  output window_max, output window_min, output latest_sample,
                  output last_level, input ready);
  modport sink   (input valid, input window_level, input window_mean,
                  input window_max, input window_min, input latest_sample,
                  input last_level, output ready);
endinterface

`default_nettype wire

[rtl/core/mwrs_hist_ram.sv]
`default_nettype none

module mwrs_hist_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/mwrs_divider.sv]
`default_nettype none

module mwrs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mwrs_pkg::div_req_t req_i,
  output mwrs_pkg::div_rsp_t rsp_o
);
  import mwrs_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [SUM_W-1:0]  quo_q, quo_d;

  always_comb begin
    logic [CNT_W:0] trial;
    logic [CNT_W:0] diff;
    logic           ge;
    trial  = {rem_q, quo_q[SUM_W-1]};
    diff   = trial - {1'b0, div_q};
    ge     = (trial >= {1'b0, div_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/core/multi_window_running_stats_top.sv]
// Running mean, maximum and minimum of an unsigned Q16.16 sample stream over
// nested windows of 4, 16 and 64 samples, one result per window level for
// every request, the last one flagged. A request with restart set sets every
// statistic to its sample. Until a window has filled since the last restart
// or reset it covers all samples taken so far. The block takes one request
// at a time. A bit-serial divider giving one quotient bit per cycle is
// started for each window level, builds the 39-bit quotient and then
// presents the result, and a rescan of the stored history for a maximum or
// minimum that left a window reads one sample per cycle through the single
// read port of the history memory. A result still waiting on the output
// holds the sequencer until it is taken; the last result of a request may
// still wait on the output while the next request is taken. The history
// memory needs no clearing after reset.
`default_nettype none

module multi_window_running_stats_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  mwrs_in_if.sink           req_i,
  mwrs_out_if.source        rsp_o
);
  import mwrs_pkg::*;

  state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] r_q, r_d;
  logic                   rst_item_q, rst_item_d;
  logic [CNT_W-1:0]       steps_q, steps_d;
  logic [ADDR_W-1:0]      ptr_q, ptr_d;
  logic [LVL_W-1:0]       lvl_q, lvl_d;

  logic [SUM_W-1:0]       sum_q [WINDOW_LEVELS];
  logic [SUM_W-1:0]       sum_d [WINDOW_LEVELS];
  logic [SAMPLE_BITS-1:0] max_q [WINDOW_LEVELS];
  logic [SAMPLE_BITS-1:0] max_d [WINDOW_LEVELS];
  logic [SAMPLE_BITS-1:0] min_q [WINDOW_LEVELS];
  logic [SAMPLE_BITS-1:0] min_d [WINDOW_LEVELS];

  logic [WINDOW_LEVELS-1:0] need_max_q, need_max_d;
  logic [WINDOW_LEVELS-1:0] need_min_q, need_min_d;

  logic [CNT_W-1:0]       scan_end_q, scan_end_d;
  logic [CNT_W-1:0]       scan_j_q, scan_j_d;
  logic [CNT_W-1:0]       proc_j_q, proc_j_d;
  logic                   proc_vld_q, proc_vld_d;
  logic [SAMPLE_BITS-1:0] run_max_q, run_max_d;
  logic [SAMPLE_BITS-1:0] run_min_q, run_min_d;

  logic               out_vld_q, out_vld_d;
  logic [LEVEL_W-1:0] out_lvl_q, out_lvl_d;
  logic [DATA_W-1:0]  out_mean_q, out_mean_d;
  logic [DATA_W-1:0]  out_max_q, out_max_d;
  logic [DATA_W-1:0]  out_min_q, out_min_d;
  logic [DATA_W-1:0]  out_latest_q, out_latest_d;
  logic               out_last_q, out_last_d;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  len_t             len_cur;
  logic             last_lvl;
  logic             full_cur;
  logic             any_need;
  logic [ADDR_W-1:0] ptr_next;

  assign len_cur  = WIN_LEN[lvl_q];
  assign last_lvl = (lvl_q == LVL_W'(WINDOW_LEVELS - 1));
  assign full_cur = !rst_item_q && (steps_q >= len_cur);
  assign any_need = (|need_max_d) || (|need_min_d);
  assign ptr_next = (ptr_q == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  mwrs_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (r_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mwrs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (full_cur) begin
          state_d = ST_LEAVE;
        end else if (last_lvl) begin
          state_d = any_need ? ST_SCAN : ST_DIV;
        end
      end
      ST_LEAVE: begin
        if (last_lvl) begin
          state_d = any_need ? ST_SCAN : ST_DIV;
        end else begin
          state_d = ST_LEVEL;
        end
      end
      ST_SCAN: begin
        if (proc_vld_q && (proc_j_q == scan_end_q)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q) begin
          state_d = last_lvl ? ST_WRITE : ST_DIV;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    logic [SAMPLE_BITS-1:0] rd;
    logic [SAMPLE_BITS-1:0] new_max;
    logic [SAMPLE_BITS-1:0] new_min;
    rd           = mem_rdata;
    new_max      = (rd > run_max_q) ? rd : run_max_q;
    new_min      = (rd < run_min_q) ? rd : run_min_q;
    req_i.ready  = (state_q == ST_IDLE);
    r_d          = r_q;
    rst_item_d   = rst_item_q;
    steps_d      = steps_q;
    ptr_d        = ptr_q;
    lvl_d        = lvl_q;
    sum_d        = sum_q;
    max_d        = max_q;
    min_d        = min_q;
    need_max_d   = need_max_q;
    need_min_d   = need_min_q;
    scan_end_d   = scan_end_q;
    scan_j_d     = scan_j_q;
    proc_j_d     = proc_j_q;
    proc_vld_d   = proc_vld_q;
    run_max_d    = run_max_q;
    run_min_d    = run_min_q;
    out_vld_d    = out_vld_q;
    out_lvl_d    = out_lvl_q;
    out_mean_d   = out_mean_q;
    out_max_d    = out_max_q;
    out_min_d    = out_min_q;
    out_latest_d = out_latest_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = rst_item_q ? ptr_q : ptr_next;
    mem_raddr    = hist_addr(ptr_q, len_cur - 1'b1);
    div_req.start    = 1'b0;
    div_req.dividend = sum_q[lvl_q];
    if (rst_item_q) begin
      div_req.divisor = CNT_W'(1);
    end else if (!full_cur) begin
      div_req.divisor = steps_q + 1'b1;
    end else begin
      div_req.divisor = len_cur;
    end

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          r_d        = SAMPLE_BITS'(req_i.sample);
          rst_item_d = req_i.restart;
          lvl_d      = '0;
          need_max_d = '0;
          need_min_d = '0;
          scan_j_d   = '0;
          proc_vld_d = 1'b0;
          run_max_d  = SAMPLE_BITS'(req_i.sample);
          run_min_d  = SAMPLE_BITS'(req_i.sample);
        end
      end
      ST_LEVEL: begin
        if (rst_item_q) begin
          sum_d[lvl_q] = SUM_W'(r_q);
          max_d[lvl_q] = r_q;
          min_d[lvl_q] = r_q;
        end else if (!full_cur) begin
          sum_d[lvl_q] = sum_q[lvl_q] + SUM_W'(r_q);
          if (r_q > max_q[lvl_q]) begin
            max_d[lvl_q] = r_q;
          end
          if (r_q < min_q[lvl_q]) begin
            min_d[lvl_q] = r_q;
          end
        end
        if (!full_cur && !last_lvl) begin
          lvl_d = lvl_q + 1'b1;
        end else if (!full_cur) begin
          lvl_d = '0;
        end
      end
      ST_LEAVE: begin
        sum_d[lvl_q] = sum_q[lvl_q] - SUM_W'(rd) + SUM_W'(r_q);
        if (rd < max_q[lvl_q]) begin
          if (r_q > max_q[lvl_q]) begin
            max_d[lvl_q] = r_q;
          end
        end else begin
          need_max_d[lvl_q] = 1'b1;
          scan_end_d        = len_cur - CNT_W'(2);
        end
        if (rd > min_q[lvl_q]) begin
          if (r_q < min_q[lvl_q]) begin
            min_d[lvl_q] = r_q;
          end
        end else begin
          need_min_d[lvl_q] = 1'b1;
          scan_end_d        = len_cur - CNT_W'(2);
        end
        lvl_d = last_lvl ? '0 : lvl_q + 1'b1;
      end
      ST_SCAN: begin
        mem_raddr  = hist_addr(ptr_q, scan_j_q);
        proc_vld_d = 1'b1;
        proc_j_d   = scan_j_q;
        if (scan_j_q != scan_end_q) begin
          scan_j_d = scan_j_q + 1'b1;
        end
        if (proc_vld_q) begin
          run_max_d = new_max;
          run_min_d = new_min;
          for (int k = 0; k < WINDOW_LEVELS; k++) begin
            if (proc_j_q == WIN_LEN[k] - CNT_W'(2)) begin
              if (need_max_q[k]) begin
                max_d[k] = new_max;
              end
              if (need_min_q[k]) begin
                min_d[k] = new_min;
              end
            end
          end
        end
      end
      ST_DIV: begin
        div_req.start = 1'b1;
      end
      ST_DWAIT: begin
      end
      ST_EMIT: begin
        if (!out_vld_q) begin
          out_vld_d    = 1'b1;
          out_lvl_d    = LEVEL_W'(lvl_q);
          out_mean_d   = DATA_W'(div_rsp.quotient);
          out_max_d    = DATA_W'(max_q[lvl_q]);
          out_min_d    = DATA_W'(min_q[lvl_q]);
          out_latest_d = DATA_W'(r_q);
          out_last_d   = last_lvl;
          if (!last_lvl) begin
            lvl_d = lvl_q + 1'b1;
          end
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        ptr_d  = mem_waddr;
        if (rst_item_q) begin
          steps_d = CNT_W'(1);
        end else if (steps_q != CNT_W'(HISTORY_DEPTH)) begin
          steps_d = steps_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rst_item_q <= 1'b0;
      steps_q    <= '0;
      ptr_q      <= '0;
      lvl_q      <= '0;
      need_max_q <= '0;
      need_min_q <= '0;
      scan_end_q <= '0;
      scan_j_q   <= '0;
      proc_j_q   <= '0;
      proc_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int k = 0; k < WINDOW_LEVELS; k++) begin
        sum_q[k] <= '0;
        max_q[k] <= '0;
        min_q[k] <= '0;
      end
    end else begin
      state_q    <= state_d;
      rst_item_q <= rst_item_d;
      steps_q    <= steps_d;
      ptr_q      <= ptr_d;
      lvl_q      <= lvl_d;
      need_max_q <= need_max_d;
      need_min_q <= need_min_d;
      scan_end_q <= scan_end_d;
      scan_j_q   <= scan_j_d;
      proc_j_q   <= proc_j_d;
      proc_vld_q <= proc_vld_d;
      out_vld_q  <= out_vld_d;
      sum_q      <= sum_d;
      max_q      <= max_d;
      min_q      <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q          <= r_d;
    run_max_q    <= run_max_d;
    run_min_q    <= run_min_d;
    out_lvl_q    <= out_lvl_d;
    out_mean_q   <= out_mean_d;
    out_max_q    <= out_max_d;
    out_min_q    <= out_min_d;
    out_latest_q <= out_latest_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.window_level  = out_lvl_q;
  assign rsp_o.window_mean   = out_mean_q;
  assign rsp_o.window_max    = out_max_q;
  assign rsp_o.window_min    = out_min_q;
  assign rsp_o.latest_sample = out_latest_q;
  assign rsp_o.last_level    = out_last_q;

endmodule

`default_nettype wire

[rtl/core/mwrs_checker.sv]
`default_nettype none
`include "multi_window_running_stats_top_macros.svh"

module mwrs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [mwrs_pkg::DATA_W-1:0] in_sample_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [mwrs_pkg::DATA_W-1:0] out_mean_i,
  input wire logic [mwrs_pkg::DATA_W-1:0] out_latest_i,
  input wire logic                        out_last_i
);
  import mwrs_pkg::*;

  logic [DATA_W-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_i) begin
      sample_q <= DATA_W'(SAMPLE_BITS'(in_sample_i));
    end
  end

  `MWRS_ASSERT_NEXT(a_busy_after_request, in_valid_i && in_ready_i, !in_ready_i, "ready after request")
  `MWRS_ASSERT_HOLDS(a_latest_is_request, $rose(out_valid_i), out_latest_i == sample_q, "latest sample mismatch")
  `MWRS_ASSERT_NEXT(a_levels_keep_busy, out_valid_i && out_ready_i && !out_last_i, !in_ready_i, "ready before last level")
  `MWRS_ASSERT_NEXT(a_result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_mean_i) && $stable(out_latest_i), "stalled result changed")

endmodule

bind multi_window_running_stats_top mwrs_checker u_mwrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_sample_i  (req_i.sample),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_mean_i   (rsp_o.window_mean),
  .out_latest_i (rsp_o.latest_sample),
  .out_last_i   (rsp_o.last_level)
);

`default_nettype wire

[test/multi_window_running_stats_top_tb.sv]
`timescale 1ns / 1ps

module multi_window_running_stats_top_tb;
  import mwrs_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 400;
  localparam int DRAIN_CYCLES  = 250;
  localparam int IDLE_PERCENT  = 37;
  localparam int BURST_FIRST   = 200;
  localparam int BURST_LAST    = 280;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [DATA_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef enum int {
    MIX_FULL,
    MIX_FEW,
    MIX_EDGE,
    MIX_RAMP_UP,
    MIX_RAMP_DOWN,
    MIX_NARROW
  } value_mix_e;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              restart;
  } sample_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] window_level;
    logic [DATA_W-1:0]  window_mean;
    logic [DATA_W-1:0]  window_max;
    logic [DATA_W-1:0]  window_min;
    logic [DATA_W-1:0]  latest_sample;
    logic               last_level;
  } stat_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mwrs_in_if  sample_bus ();
  mwrs_out_if stats_bus ();

  multi_window_running_stats_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sample_bus),
    .rsp_o  (stats_bus)
  );

  always #6 clk_i = ~clk_i;

  sample_req_t  sample_queue [$];
  stat_result_t stats_expected [$];

  logic [DATA_W-1:0] hist_mem [HISTORY_DEPTH];
  logic [SUM_W-1:0]  win_sum [WINDOW_LEVELS];
  logic [DATA_W-1:0] win_max [WINDOW_LEVELS];
  logic [DATA_W-1:0] win_min [WINDOW_LEVELS];
  int                steps_taken = 0;

  int items_total    = 0;
  int items_accepted = 0;
  int restart_count  = 0;
  int rescan_count   = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int stray_count    = 0;
  int cycle_count    = 0;

  sample_req_t  next_req;
  stat_result_t got_res;
  stat_result_t want_res;

  function automatic bit take_break();
    if (items_accepted >= BURST_FIRST && items_accepted < BURST_LAST) begin
      return 1'b0;
    end
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  function automatic void push_req(logic [DATA_W-1:0] smp, logic rs);
    sample_req_t req;
    req.sample  = smp;
    req.restart = rs;
    sample_queue.push_back(req);
  endfunction

  function automatic void predict_window_stats(logic [DATA_W-1:0] smp, logic rs);
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] leaving;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
    stat_result_t      res;
    int                len;
    int                first;
    int                divisor;
    int                count;
    r     = smp & SAMPLE_MASK;
    count = steps_taken;
    if (rs) begin
      restart_count++;
    end
    for (int k = 0; k < WINDOW_LEVELS; k++) begin
      len = 1;
      for (int i = 0; i <= k; i++) begin
        len = len * WINDOW_BASE;
        if (len >= HISTORY_DEPTH) begin
          len = HISTORY_DEPTH;
        end
      end
      if (rs) begin
        win_sum[k] = SUM_W'(r);
        win_max[k] = r;
        win_min[k] = r;
        divisor    = 1;
      end else if (count < len) begin
        win_sum[k] = win_sum[k] + SUM_W'(r);
        if (r > win_max[k]) begin
          win_max[k] = r;
        end
        if (r < win_min[k]) begin
          win_min[k] = r;
        end
        divisor = count + 1;
      end else begin
        first      = HISTORY_DEPTH - len;
        leaving    = hist_mem[first];
        win_sum[k] = win_sum[k] - SUM_W'(leaving) + SUM_W'(r);
        if (leaving < win_max[k]) begin
          if (r > win_max[k]) begin
            win_max[k] = r;
          end
        end else begin
          hi = r;
          for (int j = first + 1; j < HISTORY_DEPTH; j++) begin
            if (hist_mem[j] > hi) begin
              hi = hist_mem[j];
            end
          end
          win_max[k] = hi;
          rescan_count++;
        end
        if (leaving > win_min[k]) begin
          if (r < win_min[k]) begin
            win_min[k] = r;
          end
        end else begin
          lo = r;
          for (int j = first + 1; j < HISTORY_DEPTH; j++) begin
            if (hist_mem[j] < lo) begin
              lo = hist_mem[j];
            end
          end
          win_min[k] = lo;
          rescan_count++;
        end
        divisor = len;
      end
      res.window_level  = LEVEL_W'(k);
      res.window_mean   = DATA_W'(win_sum[k] / SUM_W'(divisor));
      res.window_max    = win_max[k];
      res.window_min    = win_min[k];
      res.latest_sample = r;
      res.last_level    = (k == WINDOW_LEVELS - 1);
      stats_expected.push_back(res);
    end
    if (rs) begin
      hist_mem[HISTORY_DEPTH-1] = r;
      steps_taken = 1;
    end else begin
      for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
        hist_mem[j] = hist_mem[j+1];
      end
      hist_mem[HISTORY_DEPTH-1] = r;
      if (steps_taken < HISTORY_DEPTH) begin
        steps_taken++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bus.valid   <= 1'b0;
      sample_bus.sample  <= '0;
      sample_bus.restart <= 1'b0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        predict_window_stats(sample_bus.sample, sample_bus.restart);
        items_accepted++;
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (sample_queue.size() != 0 && !take_break()) begin
          next_req = sample_queue.pop_front();
          sample_bus.valid   <= 1'b1;
          sample_bus.sample  <= next_req.sample;
          sample_bus.restart <= next_req.restart;
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_bus.ready <= 1'b0;
    end else begin
      if (stats_bus.valid && stats_bus.ready) begin
        got_res.window_level  = stats_bus.window_level;
        got_res.window_mean   = stats_bus.window_mean;
        got_res.window_max    = stats_bus.window_max;
        got_res.window_min    = stats_bus.window_min;
        got_res.latest_sample = stats_bus.latest_sample;
        got_res.last_level    = stats_bus.last_level;
        results_seen++;
        if (stats_expected.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= REPORT_LIMIT) begin
            $display("unexpected result: level %0d mean %h max %h min %h latest %h last %b",
                     got_res.window_level, got_res.window_mean, got_res.window_max,
                     got_res.window_min, got_res.latest_sample, got_res.last_level);
          end
        end else begin
          want_res = stats_expected.pop_front();
          if (got_res.window_level !== want_res.window_level ||
              got_res.window_mean !== want_res.window_mean ||
              got_res.window_max !== want_res.window_max ||
              got_res.window_min !== want_res.window_min ||
              got_res.latest_sample !== want_res.latest_sample ||
              got_res.last_level !== want_res.last_level) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= REPORT_LIMIT) begin
              $display("mismatch at result %0d:", results_seen);
              $display("  expected level %0d mean %h max %h min %h latest %h last %b",
                       want_res.window_level, want_res.window_mean, want_res.window_max,
                       want_res.window_min, want_res.latest_sample, want_res.last_level);
              $display("  actual   level %0d mean %h max %h min %h latest %h last %b",
                       got_res.window_level, got_res.window_mean, got_res.window_max,
                       got_res.window_min, got_res.latest_sample, got_res.last_level);
            end
          end
        end
      end
      stats_bus.ready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("multi_window_running_stats_top_tb: errors");
      $finish;
    end
  end

  initial begin
    int                errors;
    int                run_len;
    int                generated;
    value_mix_e        mix;
    logic [DATA_W-1:0] ramp_val;
    logic [DATA_W-1:0] ramp_step;
    logic [DATA_W-1:0] smp;
    logic              rs;

    rst_ni             = 1'b0;
    sample_bus.valid   = 1'b0;
    sample_bus.sample  = '0;
    sample_bus.restart = 1'b0;
    stats_bus.ready    = 1'b0;

    for (int k = 0; k < WINDOW_LEVELS; k++) begin
      win_sum[k] = '0;
      win_max[k] = '0;
      win_min[k] = '0;
    end
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      hist_mem[j] = '0;
    end

    // before any restart, then a first restart
    push_req(32'h0001_2345, 1'b0);
    push_req(32'hFFFF_FFFF, 1'b0);
    push_req(32'h0000_0000, 1'b0);
    push_req(32'hFFFF_FFFF, 1'b1);
    push_req(32'h0000_0000, 1'b0);
    push_req(32'hFFFF_FFFF, 1'b0);
    push_req(32'h8000_0000, 1'b0);
    push_req(32'h0000_0001, 1'b0);
    push_req(32'h7FFF_FFFF, 1'b0);
    // back-to-back restarts, then fill the shortest window and drop equal extremes
    push_req(32'h0000_0000, 1'b1);
    push_req(32'h0001_0000, 1'b1);
    push_req(32'hAAAA_AAAA, 1'b0);
    push_req(32'h5555_5555, 1'b0);
    push_req(32'h0001_0000, 1'b0);
    push_req(32'h0001_0000, 1'b0);
    push_req(32'hFFFF_FFFF, 1'b0);
    push_req(32'h0000_0000, 1'b0);
    push_req(32'h0001_0000, 1'b0);
    push_req(32'h0001_0000, 1'b0);
    push_req(32'h0001_0000, 1'b0);

    generated = 0;
    while (generated < RANDOM_ITEMS) begin
      run_len   = ($urandom_range(99) < 70) ? $urandom_range(70, 140) : $urandom_range(1, 20);
      mix       = value_mix_e'($urandom_range(0, 5));
      ramp_val  = $urandom;
      ramp_step = $urandom_range(1, 32'h00FF_FFFF);
      for (int i = 0; i < run_len && generated < RANDOM_ITEMS; i++) begin
        rs = (i == 0) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 2);
        case (mix)
          MIX_FEW: begin
            case ($urandom_range(0, 3))
              0:       smp = 32'h0000_0000;
              1:       smp = 32'h0001_0000;
              2:       smp = 32'h8000_0000;
              default: smp = 32'hFFFF_FFFF;
            endcase
          end
          MIX_EDGE: begin
            smp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          end
          MIX_RAMP_UP: begin
            ramp_val = ramp_val + ramp_step;
            smp      = ramp_val;
          end
          MIX_RAMP_DOWN: begin
            ramp_val = ramp_val - ramp_step;
            smp      = ramp_val;
          end
          MIX_NARROW: begin
            smp = $urandom_range(0, 32'h0003_FFFF);
          end
          default: begin
            smp = $urandom;
          end
        endcase
        push_req(smp, rs);
        generated++;
      end
    end
    items_total = sample_queue.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted != items_total) @(posedge clk_i);
    while (stats_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    errors = mismatch_count + stray_count + stats_expected.size();
    $display("%0d requests with %0d restarts, %0d window results checked, %0d extreme rescans",
             items_accepted, restart_count, results_seen, rescan_count);
    $display("%0d mismatches, %0d unexpected results, %0d results missing",
             mismatch_count, stray_count, stats_expected.size());
    if (errors == 0) begin
      $display("multi_window_running_stats_top_tb: clean");
    end else begin
      $display("multi_window_running_stats_top_tb: errors");
    end
    $finish;
  end

endmodule
